// ----- design/assert_macros.svh -----
// Assertion shorthands for the dimmer checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dimmer check failed");

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dimmer check failed");

`endif

// ----- design/rotenc_pkg.sv -----
package rotenc_pkg;

	localparam int unsigned LEVEL_W    = 16;
	localparam int unsigned STEP_W     = 12;
	localparam int unsigned LOCKOUT_W  = 20;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 20;

	localparam logic [LEVEL_W-1:0]   PERIOD_RESET   = 16'd1000;
	localparam logic [STEP_W-1:0]    STEP_RESET     = 12'd25;
	localparam logic [LOCKOUT_W-1:0] DEBOUNCE_RESET = 20'd100000;
	localparam logic [LEVEL_W-1:0]   RESTORE_RESET  = 16'd500;
	localparam logic [LEVEL_W-1:0]   BRIGHT_RESET   = 16'd500;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PWM_PERIOD     = 2'd0,
		REG_LEVEL_STEP     = 2'd1,
		REG_DEBOUNCE_TICKS = 2'd2,
		REG_RESTORE_LEVEL  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic track_a;
		logic track_b;
		logic switch_n;
	} in_item_t;

	typedef struct packed {
		logic               pwm_out;
		logic [LEVEL_W-1:0] applied_level;
		logic               leds_on;
	} out_item_t;

	typedef struct packed {
		logic [LEVEL_W-1:0]   pwm_period;
		logic [STEP_W-1:0]    level_step;
		logic [LOCKOUT_W-1:0] debounce_ticks;
		logic [LEVEL_W-1:0]   restore_level;
	} cfg_t;

	typedef struct packed {
		logic               leds_on;
		logic [LEVEL_W-1:0] level;
	} level_t;

endpackage

// ----- design/rotenc_level.sv -----
module rotenc_level (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  rotenc_pkg::in_item_t item,
	input  rotenc_pkg::cfg_t     cfg,
	output rotenc_pkg::level_t   lvl
);
	import rotenc_pkg::*;

	logic                 prev_track_q;
	logic                 prev_pressed_q;
	logic [LOCKOUT_W-1:0] lockout_q;
	logic [LEVEL_W-1:0]   bright_q;
	logic                 enabled_q;

	logic                 pressed;
	logic                 prev_pressed_d;
	logic [LOCKOUT_W-1:0] lockout_d;
	logic [LEVEL_W-1:0]   bright_mid;
	logic                 enabled_d;
	logic [LEVEL_W-1:0]   bright_d;
	logic [LEVEL_W:0]     sum;
	logic [LEVEL_W-1:0]   step_ext;

	assign pressed  = ~item.switch_n;
	assign step_ext = {{(LEVEL_W-STEP_W){1'b0}}, cfg.level_step};
	assign sum      = {1'b0, bright_mid} + {1'b0, step_ext};

	always_comb begin
		prev_pressed_d = prev_pressed_q;
		lockout_d      = lockout_q;
		bright_mid     = bright_q;
		enabled_d      = enabled_q;
		// switch first: lockout countdown masks it
		priority if (lockout_q != '0) begin
			lockout_d = lockout_q - LOCKOUT_W'(1);
		end else if (pressed != prev_pressed_q) begin
			prev_pressed_d = pressed;
			lockout_d      = cfg.debounce_ticks;
			if (pressed) begin
				priority if (!enabled_q) begin
					enabled_d = 1'b1;
				end else if (bright_q == '0) begin
					bright_mid = cfg.restore_level;
				end else begin
					enabled_d = 1'b0;
				end
			end
		end

		// detent sees the updated enable
		bright_d = bright_mid;
		if ((item.track_a != prev_track_q) && enabled_d) begin
			if (item.track_a == item.track_b) begin
				bright_d = (sum > {1'b0, cfg.pwm_period}) ? cfg.pwm_period
				                                          : sum[LEVEL_W-1:0];
			end else begin
				bright_d = (bright_mid < step_ext) ? '0 : bright_mid - step_ext;
			end
		end
	end

	assign lvl.leds_on = enabled_d;
	assign lvl.level   = enabled_d ? bright_d : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_track_q   <= 1'b0;
			prev_pressed_q <= 1'b0;
			lockout_q      <= '0;
			bright_q       <= BRIGHT_RESET;
			enabled_q      <= 1'b0;
		end else if (advance) begin
			prev_track_q   <= item.track_a;
			prev_pressed_q <= prev_pressed_d;
			lockout_q      <= lockout_d;
			bright_q       <= bright_d;
			enabled_q      <= enabled_d;
		end
	end

endmodule

// ----- design/rotenc_pwm.sv -----
module rotenc_pwm (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           advance,
	input  logic [rotenc_pkg::LEVEL_W-1:0] period,
	input  rotenc_pkg::level_t             lvl,
	output rotenc_pkg::out_item_t          result
);
	import rotenc_pkg::*;

	logic [LEVEL_W-1:0] cnt_q;
	logic [LEVEL_W:0]   cnt_inc;

	assign cnt_inc = {1'b0, cnt_q} + (LEVEL_W+1)'(1);

	// compare the count as it stood before this tick's advance
	assign result.pwm_out       = (cnt_q < lvl.level);
	assign result.applied_level = lvl.level;
	assign result.leds_on       = lvl.leds_on;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (advance) begin
			cnt_q <= (cnt_inc >= {1'b0, period}) ? '0 : cnt_inc[LEVEL_W-1:0];
		end
	end

endmodule

// ----- design/rotary_encoder_pwm_dimmer.sv -----
// Rotary encoder LED dimmer with compare-based PWM. Each input beat is one PWM
// tick carrying both encoder channels and the active-low push switch; each
// accepted beat yields exactly one result beat (PWM bit, driven level, on flag),
// through the input and result registers. One beat is taken every cycle while
// the result register is free: the brightness, lockout and PWM counter state
// are updated once per beat by a single pass of logic between the input
// register and the result register. Configuration writes are always ready and
// take effect on the next beat; write them only while no beat is in flight.
module rotary_encoder_pwm_dimmer (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  rotenc_pkg::in_item_t                  in_data,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output rotenc_pkg::out_item_t                 out_data,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [rotenc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rotenc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import rotenc_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      out_valid_q;
	out_item_t out_data_q;
	cfg_t      cfg_q;
	logic      advance;
	level_t    lvl;
	out_item_t result;

	// move stage 1 into the result register when that register is free
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pwm_period     <= PERIOD_RESET;
			cfg_q.level_step     <= STEP_RESET;
			cfg_q.debounce_ticks <= DEBOUNCE_RESET;
			cfg_q.restore_level  <= RESTORE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PWM_PERIOD:     cfg_q.pwm_period     <= cfg_data[LEVEL_W-1:0];
				REG_LEVEL_STEP:     cfg_q.level_step     <= cfg_data[STEP_W-1:0];
				REG_DEBOUNCE_TICKS: cfg_q.debounce_ticks <= cfg_data[LOCKOUT_W-1:0];
				REG_RESTORE_LEVEL:  cfg_q.restore_level  <= cfg_data[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= result;
		end
	end

	rotenc_level u_level (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg_q),
		.lvl     (lvl)
	);

	rotenc_pwm u_pwm (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.period  (cfg_q.pwm_period),
		.lvl     (lvl),
		.result  (result)
	);

endmodule

// ----- design/rotenc_checker.sv -----
`include "assert_macros.svh"

module rotenc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input rotenc_pkg::out_item_t             out_data
);
	import rotenc_pkg::*;

	// LEDs off drive nothing
	`ASSERT_IMPL(a_off_zero, clk, arst_n, out_valid && !out_data.leds_on, out_data.applied_level == '0)
	// a high PWM bit needs a nonzero level
	`ASSERT_IMPL(a_pwm_level, clk, arst_n, out_valid && out_data.pwm_out, out_data.applied_level != '0)
	// an accepted beat reaches the result register when the output is not stalled
	`ASSERT_NEXT(a_latency, clk, arst_n, (in_valid && !in_stall) ##1 !out_stall, out_valid)
	// stalled result holds
	`ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind rotary_encoder_pwm_dimmer rotenc_checker u_rotenc_checker (.*);

// ----- sim/tb_rotary_encoder_pwm_dimmer.sv -----
`timescale 1ns / 100ps

module tb_rotary_encoder_pwm_dimmer;
	import rotenc_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	rotary_encoder_pwm_dimmer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	in_item_t  tick_q[$];
	out_item_t drive_q[$];
	int        idle_pct = 35;
	int        n_err = 0;
	int        quiet = 0;
	int        hold_left = 0;
	logic      hold_start = 1'b0;

	// dimmer state as the block should hold it
	cfg_t           dim_cfg;
	logic           enc_prev;
	logic           sw_pressed;
	logic [19:0]    lock_cnt;
	logic [15:0]    bright;
	logic           leds_en;
	logic [15:0]    pwm_cnt;

	// encoder and switch pin levels for stimulus
	logic cur_a = 1'b0;
	logic cur_b = 1'b0;
	logic cur_sw = 1'b1;

	function automatic out_item_t next_drive(input in_item_t t);
		logic        pressed;
		logic [31:0] sum;
		logic [31:0] cnt;
		logic [15:0] level;
		out_item_t   o;
		pressed = ~t.switch_n;
		cnt = 32'(pwm_cnt);
		if (lock_cnt != 0) begin
			lock_cnt = lock_cnt - 20'd1;
		end else if (pressed != sw_pressed) begin
			sw_pressed = pressed;
			lock_cnt = dim_cfg.debounce_ticks;
			if (pressed) begin
				if (!leds_en)
					leds_en = 1'b1;
				else if (bright == 0)
					bright = dim_cfg.restore_level;
				else
					leds_en = 1'b0;
			end
		end
		if (t.track_a != enc_prev && leds_en) begin
			if (t.track_a == t.track_b) begin
				sum = 32'(bright) + 32'(dim_cfg.level_step);
				bright = (sum > 32'(dim_cfg.pwm_period)) ? dim_cfg.pwm_period : sum[15:0];
			end else begin
				bright = (bright < 16'(dim_cfg.level_step)) ? '0
					: bright - 16'(dim_cfg.level_step);
			end
		end
		enc_prev = t.track_a;
		level = leds_en ? bright : '0;
		o.pwm_out = (cnt < 32'(level));
		o.applied_level = level;
		o.leds_on = leds_en;
		if (cnt + 32'd1 >= 32'(dim_cfg.pwm_period))
			pwm_cnt = '0;
		else
			pwm_cnt = cnt[15:0] + 16'd1;
		return o;
	endfunction

	// sender: offer queued ticks, hold a stalled beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				drive_q.push_back(next_drive(in_data));
			if (!in_valid || !in_stall) begin
				if (tick_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
					in_valid <= 1'b1;
					in_data <= tick_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: check each result beat against the oldest expected drive
	always @(posedge clk) begin : mon
		out_item_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (drive_q.size() == 0) begin
					$display("%0t: unexpected result beat %p", $time, out_data);
					n_err++;
				end else begin
					want = drive_q.pop_front();
					if (out_data.pwm_out !== want.pwm_out) begin
						$display("%0t: pwm_out expected %0b got %0b", $time,
							want.pwm_out, out_data.pwm_out);
						n_err++;
					end
					if (out_data.applied_level !== want.applied_level) begin
						$display("%0t: applied_level expected %0d got %0d", $time,
							want.applied_level, out_data.applied_level);
						n_err++;
					end
					if (out_data.leds_on !== want.leds_on) begin
						$display("%0t: leds_on expected %0b got %0b", $time,
							want.leds_on, out_data.leds_on);
						n_err++;
					end
				end
			end
			if (hold_start) begin
				out_stall <= 1'b1;
				hold_left <= HOLD_CYCLES;
			end else if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else begin
				out_stall <= ($urandom_range(99) < idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_PWM_PERIOD:     dim_cfg.pwm_period = val[LEVEL_W-1:0];
			REG_LEVEL_STEP:     dim_cfg.level_step = val[STEP_W-1:0];
			REG_DEBOUNCE_TICKS: dim_cfg.debounce_ticks = val[LOCKOUT_W-1:0];
			REG_RESTORE_LEVEL:  dim_cfg.restore_level = val[LEVEL_W-1:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [19:0] period, input logic [19:0] step,
			input logic [19:0] deb, input logic [19:0] restore);
		write_reg(REG_PWM_PERIOD, period);
		write_reg(REG_LEVEL_STEP, step);
		write_reg(REG_DEBOUNCE_TICKS, deb);
		write_reg(REG_RESTORE_LEVEL, restore);
	endtask

	task automatic put();
		tick_q.push_back('{track_a: cur_a, track_b: cur_b, switch_n: cur_sw});
	endtask

	// one detent on the tracked channel
	task automatic turn(input logic cw);
		cur_a = ~cur_a;
		cur_b = cw ? cur_a : ~cur_a;
		put();
	endtask

	// press and release, each held for the given number of ticks
	task automatic tap(input int hold);
		cur_sw = 1'b0;
		repeat (hold) put();
		cur_sw = 1'b1;
		repeat (hold) put();
	endtask

	// quadrature steps with a random direction bias, some switch activity and noise
	task automatic fill_random(input int n);
		int r;
		int fwd_bias;
		fwd_bias = $urandom_range(80, 20);
		repeat (n) begin
			r = $urandom_range(99);
			if (r < 8) begin
				cur_a = 1'($urandom_range(1));
				cur_b = 1'($urandom_range(1));
				cur_sw = 1'($urandom_range(1));
			end else begin
				if (r < 50) begin
					if (($urandom_range(99) < fwd_bias) == (cur_a == cur_b))
						cur_a = ~cur_a;
					else
						cur_b = ~cur_b;
				end
				if ($urandom_range(99) < 6)
					cur_sw = ~cur_sw;
			end
			put();
		end
	endtask

	// wait until every queued tick has been taken and every drive checked
	task automatic drain();
		while (tick_q.size() != 0 || in_valid || drive_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		dim_cfg = '{PERIOD_RESET, STEP_RESET, DEBOUNCE_RESET, RESTORE_RESET};
		enc_prev = 1'b0;
		sw_pressed = 1'b0;
		lock_cnt = '0;
		bright = BRIGHT_RESET;
		leds_en = 1'b0;
		pwm_cnt = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: detents while off are ignored
		turn(1'b1);
		turn(1'b0);
		put();
		drain();

		// brightness above period, clamp, floor, restore at zero, switch off
		write_all(20'd100, 20'd4095, 20'd1, 20'd65535);
		tap(2);
		turn(1'b1);
		turn(1'b0);
		tap(2);
		turn(1'b0);
		tap(2);
		turn(1'b1);
		drain();

		// zero period and zero step
		write_all(20'd0, 20'd0, 20'd0, 20'd65535);
		tap(1);
		turn(1'b1);
		turn(1'b0);
		tap(1);
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: write_all(20'd1, 20'd1, 20'd0, 20'd0);
				1: write_all(20'd65535, 20'd4095, 20'd3, 20'd65535);
				3: write_all(20'd0, 20'($urandom_range(64, 1)), 20'($urandom_range(6)),
					20'($urandom_range(300)));
				// last: the switch locks out for the rest of the run
				9: write_all(20'($urandom_range(300, 1)), 20'($urandom_range(64, 1)),
					20'hFFFFF, 20'($urandom_range(300)));
				default: write_all(20'($urandom_range(400, 1)), 20'($urandom_range(80)),
					20'($urandom_range(10)), 20'($urandom_range(500)));
			endcase
			idle_pct = (ph == 2) ? 0 : 35;
			fill_random(150);
			if (ph == 2 || ph == 6) begin
				@(posedge clk);
				hold_start <= 1'b1;
				@(posedge clk);
				hold_start <= 1'b0;
			end
			drain();
		end

		repeat (10) @(posedge clk);
		if (n_err == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
